// ----- design/kmg_pkg.sv -----
// ----------------------------------------------------------------------------
// kmg_pkg
// Shared types and constants of the k-way sorted merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmg_pkg;

  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 8;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 3;
  localparam int LIST_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int PTR_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
  localparam int TOTAL_W = $clog2(NUM_LISTS * LIST_DEPTH + 1);
  localparam int CNT_W   = $clog2(NUM_LISTS + 1);

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(NUM_LISTS);

  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } kmg_state_t;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic                    clear;
    logic [LIST_W-1:0]       sel;
    logic signed [VAL_W-1:0] value;
  } kmg_ctrl_t;

  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] value;
    logic [LIST_W-1:0]       idx;
  } kmg_cand_t;

  localparam kmg_cand_t CAND_NONE = '{vld: 1'b0, value: '0, idx: '0};

endpackage

`default_nettype wire

// ----- design/kmg_in_if.sv -----
// ----------------------------------------------------------------------------
// kmg_in_if
// Input channel of the merge block: push and finish items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmg_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [2:0]         list_index;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output list_index, output value, input ready);
  modport sink   (input valid, input cmd, input list_index, input value, output ready);
endinterface

`default_nettype wire

// ----- design/kmg_out_if.sv -----
// ----------------------------------------------------------------------------
// kmg_out_if
// Result channel of the merge block: merged values with run markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] merged_value;
  logic               last;
  logic               empty_res;

  modport source (output valid, output merged_value, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input merged_value, input last, input empty_res,
                  output ready);
endinterface

`default_nettype wire

// ----- design/kmg_cell.sv -----
// ----------------------------------------------------------------------------
// kmg_cell
// One list of the merge chain: holds its queue and passes the running
// smallest head to its right neighbor every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmg_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire [kmg_pkg::LIST_W-1:0]  my_idx,
  input  kmg_pkg::kmg_ctrl_t         ctrl,
  input  kmg_pkg::kmg_cand_t         cand_in,
  output kmg_pkg::kmg_cand_t         cand_out,
  output logic                       full
);
  import kmg_pkg::*;

  logic signed [VAL_W-1:0] q_r [LIST_DEPTH];
  logic [FILL_W-1:0]       fill_r;
  logic [FILL_W-1:0]       rd_ptr_r;
  kmg_cand_t               cand_r;
  kmg_cand_t               cand_nxt;
  logic                    sel_me;
  logic                    head_vld;
  logic signed [VAL_W-1:0] head;
  logic                    take_own;
  logic                    do_push;

  assign sel_me   = (ctrl.sel == my_idx);
  assign full     = (fill_r == FILL_W'(LIST_DEPTH));
  assign do_push  = ctrl.push && sel_me && !full;
  assign head_vld = (rd_ptr_r < fill_r);
  assign head     = q_r[rd_ptr_r[PTR_W-1:0]];
  assign take_own = head_vld && (!cand_in.vld || ($signed(head) < $signed(cand_in.value)));

  always_comb begin
    if (take_own) begin
      cand_nxt = '{vld: 1'b1, value: head, idx: my_idx};
    end else begin
      cand_nxt = cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_ptr_r <= '0;
      cand_r   <= CAND_NONE;
    end else begin
      cand_r <= cand_nxt;
      if (ctrl.clear) begin
        fill_r   <= '0;
        rd_ptr_r <= '0;
      end else begin
        if (do_push) begin
          fill_r <= fill_r + FILL_W'(1);
        end
        if (ctrl.pop && sel_me) begin
          rd_ptr_r <= rd_ptr_r + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[fill_r[PTR_W-1:0]] <= ctrl.value;
    end
  end

  assign cand_out = cand_r;

endmodule

`default_nettype wire

// ----- design/k_way_sorted_merge_top.sv -----
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// Merges up to NUM_LISTS pushed lists into one stream by smallest head.
// ----------------------------------------------------------------------------
// push item: taken while idle, next item accepted in the following cycle
// finish item: each result waits for the candidate wave that crosses the cell
//   chain one cell per cycle before each pop, and for the output to be free
// finish with all lists empty: one empty result loaded once output is free
// input is held off from finish acceptance until the last result is loaded
// reset clears list counts and output valid; stored values are left as is
`default_nettype none

module k_way_sorted_merge_top (
  input  wire        clk,
  input  wire        rst_n,
  kmg_in_if.sink     in_if,
  kmg_out_if.source  out_if
);
  import kmg_pkg::*;

  kmg_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_empty_r, out_empty_nxt;

  kmg_ctrl_t               ctrl;
  kmg_cand_t               cand [NUM_LISTS];
  logic [NUM_LISTS-1:0]    full;
  kmg_cand_t               end_cand;
  logic                    in_acc;
  logic                    in_range;
  logic                    push_ok;
  logic                    out_free;
  logic                    fire;
  logic                    run_empty;
  logic                    run_last;

  for (genvar i = 0; i < NUM_LISTS; i++) begin : g_cell
    kmg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (LIST_W'(i)),
      .ctrl     (ctrl),
      .cand_in  ((i == 0) ? CAND_NONE : cand[(i == 0) ? 0 : i - 1]),
      .cand_out (cand[i]),
      .full     (full[i])
    );
  end

  assign end_cand  = cand[NUM_LISTS-1];
  assign in_acc    = in_if.valid && in_if.ready;
  assign in_range  = ({1'b0, in_if.list_index} < IDX_LIMIT);
  assign push_ok   = in_acc && (in_if.cmd == CMD_PUSH) && in_range &&
                     !full[in_if.list_index[LIST_W-1:0]];
  assign out_free  = !out_valid_r || out_if.ready;
  assign run_empty = (total_r == '0);
  assign run_last  = (total_r <= TOTAL_W'(1));
  assign fire      = (state_r == ST_SCAN) && out_free &&
                     (run_empty || (cnt_r == CNT_W'(NUM_LISTS)));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    ctrl.push     = push_ok;
    ctrl.pop      = 1'b0;
    ctrl.clear    = 1'b0;
    ctrl.sel      = in_if.list_index[LIST_W-1:0];
    ctrl.value    = in_if.value;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (push_ok) begin
          total_nxt = total_r + TOTAL_W'(1);
        end
        if (in_acc && (in_if.cmd == CMD_FINISH)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r != CNT_W'(NUM_LISTS)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (fire) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_value_nxt = run_empty ? '0 : end_cand.value;
          out_last_nxt  = run_last;
          out_empty_nxt = run_empty;
          ctrl.sel      = end_cand.idx;
          ctrl.pop      = !run_empty;
          ctrl.clear    = run_last;
          if (!run_empty) begin
            total_nxt = total_r - TOTAL_W'(1);
          end
          if (run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.merged_value = out_value_r;
  assign out_if.last         = out_last_r;
  assign out_if.empty_res    = out_empty_r;

endmodule

`default_nettype wire

// ----- design/kmg_checker.sv -----
// ----------------------------------------------------------------------------
// kmg_checker
// Port-level checks of the merge block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] merged_value,
  input wire        last,
  input wire        empty_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_res |-> last && (merged_value == 32'd0))
    else $error("empty result must be last with zero value");

  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("input taken in the middle of a merged run");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(merged_value) && $stable(last) && $stable(empty_res))
    else $error("result item changed while stalled");

endmodule

bind k_way_sorted_merge_top kmg_checker u_kmg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .merged_value (out_if.merged_value),
  .last         (out_if.last),
  .empty_res    (out_if.empty_res)
);

`default_nettype wire

// ----- dv/k_way_sorted_merge_top_test.sv -----
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top_test
// Drives push and finish items into the merge block and checks every merged
// result against a local copy of the lists or the typed table rows, with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge_top_test;
  import kmg_pkg::*;

  localparam int DIR_N        = 24;
  localparam int RANDOM_ITEMS = 370;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    logic signed [VAL_W-1:0] e_value;
    logic                    e_last;
    logic                    e_empty;
  } dir_row_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    is_empty;
  } merge_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic res_ready = 1'b0;

  kmg_in_if  in_ch ();
  kmg_out_if out_ch ();

  assign out_ch.ready = res_ready;

  k_way_sorted_merge_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [VAL_W-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
  logic [FILL_W-1:0]       list_cnt [NUM_LISTS] = '{default: '0};
  logic signed [VAL_W-1:0] run_tail [NUM_LISTS];
  merge_res_t              pending_merged [$];
  int                      mismatch_cnt = 0;
  int                      n_counted    = 0;
  int                      cycles       = 0;
  bit                      calm_in      = 1'b0;
  bit                      calm_out     = 1'b0;

  // extremes, full list, equal heads, unsorted list, empty finish
  dir_row_t dir_tab [DIR_N] = '{
    '{CMD_FINISH, 3'd0, 32'sd0,         1'b1, 32'sd0,         1'b1, 1'b1},
    '{CMD_PUSH,   3'd7, 32'h7fff_ffff,  1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_FINISH, 3'd5, 32'hffff_ffff,  1'b1, 32'h7fff_ffff,  1'b1, 1'b0},
    '{CMD_PUSH,   3'd0, 32'h8000_0000,  1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_FINISH, 3'd0, 32'sd0,         1'b1, 32'h8000_0000,  1'b1, 1'b0},
    '{CMD_PUSH,   3'd3, -32'sd4,        1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, -32'sd3,        1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, -32'sd2,        1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, -32'sd1,        1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, 32'sd0,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, 32'sd1,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, 32'sd2,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, 32'sd3,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd3, 32'sd4,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd5, -32'sd3,        1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd5, 32'sd2,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd1, 32'sd10,        1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd1, -32'sd10,       1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_FINISH, 3'd2, 32'sd0,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_FINISH, 3'd0, 32'sd0,         1'b1, 32'sd0,         1'b1, 1'b1},
    '{CMD_PUSH,   3'd2, 32'h5555_5555,  1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd6, 32'haaaa_aaaa,  1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_PUSH,   3'd4, 32'sd0,         1'b0, 32'sd0,         1'b0, 1'b0},
    '{CMD_FINISH, 3'd7, 32'h1234_5678,  1'b0, 32'sd0,         1'b0, 1'b0}
  };

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic flag_error(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 20) $display("error: %s at cycle %0d", what, cycles);
  endtask

  // updates the list copies and queues the merged run of a finish that is not typed
  task automatic track_item(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic signed [VAL_W-1:0] val, input bit typed);
    int head [NUM_LISTS];
    int left;
    int best;
    n_counted++;
    if (cmd == CMD_PUSH) begin
      if (int'(idx) < NUM_LISTS && list_cnt[idx] < LIST_DEPTH) begin
        list_mem[idx][list_cnt[idx]] = val;
        list_cnt[idx] = list_cnt[idx] + 1'b1;
      end
    end else begin
      left = 0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head[i] = 0;
        left += int'(list_cnt[i]);
      end
      if (left == 0) begin
        if (!typed) pending_merged.push_back('{value: '0, last: 1'b1, is_empty: 1'b1});
      end else begin
        while (left > 0) begin
          best = -1;
          for (int i = 0; i < NUM_LISTS; i++) begin
            if (head[i] < int'(list_cnt[i]) &&
                (best < 0 || list_mem[i][head[i]] < list_mem[best][head[best]]))
              best = i;
          end
          left--;
          if (!typed)
            pending_merged.push_back('{value: list_mem[best][head[best]],
                                       last: (left == 0), is_empty: 1'b0});
          head[best]++;
        end
      end
      for (int i = 0; i < NUM_LISTS; i++) list_cnt[i] = '0;
    end
  endtask

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val, input bit typed);
    int gap;
    gap = calm_in ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.list_index <= idx;
    in_ch.value      <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_item(cmd, idx, val, typed);
  endtask

  // ascending values per list, sometimes repeating the previous one
  task automatic push_next(input logic [IDX_W-1:0] idx, input int span);
    longint nxt;
    send_item(CMD_PUSH, idx, run_tail[idx], 1'b0);
    nxt = longint'(run_tail[idx]);
    if ($urandom_range(0, 3) != 0) nxt += $urandom_range(1, span);
    if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
    run_tail[idx] = VAL_W'(nxt);
  endtask

  task automatic random_batch();
    int style;
    int span;
    int lo_list;
    int n_used;
    style   = $urandom_range(0, 99);
    calm_in = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 2))
      0: begin
        span = 4;
      end
      1: begin
        span = 5000;
      end
      default: begin
        span = 32'h0fff_ffff;
      end
    endcase
    for (int i = 0; i < NUM_LISTS; i++)
      run_tail[i] = ($urandom_range(0, 4) == 0) ? 32'h8000_0000 : VAL_W'($urandom);
    lo_list = $urandom_range(0, NUM_LISTS - 1);
    n_used  = $urandom_range(1, NUM_LISTS);
    if (style < 8) begin
      // fill lists to their depth and sometimes past it
      for (int l = 0; l < n_used; l++) begin
        repeat (LIST_DEPTH + $urandom_range(0, 2))
          push_next(IDX_W'((lo_list + l) % NUM_LISTS), span);
      end
    end else if (style < 22) begin
      repeat ($urandom_range(0, 10))
        send_item(CMD_PUSH, IDX_W'($urandom), VAL_W'($urandom), 1'b0);
    end else if (style >= 27) begin
      repeat ($urandom_range(1, 16))
        push_next(IDX_W'((lo_list + $urandom_range(0, n_used - 1)) % NUM_LISTS), span);
    end
    send_item(CMD_FINISH, IDX_W'($urandom), VAL_W'($urandom), 1'b0);
  endtask

  task automatic take_result();
    merge_res_t exp_r;
    if (pending_merged.size() == 0) begin
      flag_error($sformatf("result %0d with nothing pending", out_ch.merged_value));
    end else begin
      exp_r = pending_merged.pop_front();
      if (out_ch.empty_res !== exp_r.is_empty)
        flag_error($sformatf("empty_res %b, want %b", out_ch.empty_res, exp_r.is_empty));
      if (out_ch.last !== exp_r.last)
        flag_error($sformatf("last %b, want %b", out_ch.last, exp_r.last));
      if (out_ch.merged_value !== exp_r.value)
        flag_error($sformatf("merged_value %0d, want %0d", out_ch.merged_value,
                             exp_r.value));
    end
  endtask

  always @(posedge clk) begin : res_side
    int gap;
    if (out_ch.valid && out_ch.ready) take_result();
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (cycles % 300 == 0) calm_out = ($urandom_range(0, 2) == 0);
      gap = calm_out ? 0 : pick_gap();
      res_ready <= (gap == 0);
      if (gap > 1) begin
        @(posedge clk);
        repeat (gap - 2) begin
          if (out_ch.valid && out_ch.ready) take_result();
          @(posedge clk);
        end
        if (out_ch.valid && out_ch.ready) take_result();
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_PUSH;
    in_ch.list_index = '0;
    in_ch.value      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < DIR_N; r++) begin
      calm_in = (r < 12);
      send_item(dir_tab[r].cmd, dir_tab[r].idx, dir_tab[r].value, dir_tab[r].typed);
      if (dir_tab[r].typed)
        pending_merged.push_back('{value: dir_tab[r].e_value, last: dir_tab[r].e_last,
                                   is_empty: dir_tab[r].e_empty});
    end
    n_counted = 0;
    while (n_counted < RANDOM_ITEMS) random_batch();
    in_ch.valid <= 1'b0;
    while (pending_merged.size() != 0) @(posedge clk);
    repeat (4 * (NUM_LISTS + 1)) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
